FILE: rtl/wbps_pkg.sv
`default_nettype none

package wbps_pkg;

    // Default sizes of the byte window and the byte counter.
    localparam int PATTERN_MAX_DEF   = 16;
    localparam int POSITION_BITS_DEF = 32;

    // Widths fixed by the register map and the item fields.
    localparam int ELEM_MAX_HW    = 16;
    localparam int POS_OUT_BITS   = 32;
    localparam int LEN_REG_BITS   = 5;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KINDS        = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VAR_LOW      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VAR_HIGH     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LENGTH       = 3'd5;

    // Element kind codes, two bits per element.
    localparam logic [1:0] KIND_LITERAL     = 2'd0;
    localparam logic [1:0] KIND_ANY         = 2'd1;
    localparam logic [1:0] KIND_VARIABLE    = 2'd2;
    localparam logic [1:0] KIND_LITERAL_ALT = 2'd3;

    // Reset values of the register file.
    localparam logic [8*ELEM_MAX_HW-1:0] VAR_BYTES_RESET =
        128'hfffefdfcfbfaf9f8_f7f6f5f4f3f2f1f0;
    localparam logic [LEN_REG_BITS-1:0] LENGTH_RESET = 5'd1;

    typedef struct packed {
        logic [8*ELEM_MAX_HW-1:0] pattern_bytes;
        logic [2*ELEM_MAX_HW-1:0] element_kinds;
        logic [8*ELEM_MAX_HW-1:0] variable_bytes;
    } cfg_regs_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic                    found;
        logic [POS_OUT_BITS-1:0] position;
    } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/wildcard_byte_pattern_search_unit.sv
`default_nettype none

// An accepted input item is held in the input stage register; the result item that it causes
// is then registered in the result register; a stalled output holds the byte in its stage.
// Throughput: one byte per cycle; the only limit is a stalled output register.
// The window compare is a single registered pass from the input stage to the result register.
// Reset clears the byte window, the counter, the match flag and all valid flags, and loads
// the register file with its defaults (length 1, variable bytes 0xf0 to 0xff).
module wildcard_byte_pattern_search_unit #(
    parameter int PATTERN_MAX   = wbps_pkg::PATTERN_MAX_DEF,
    parameter int POSITION_BITS = wbps_pkg::POSITION_BITS_DEF
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_stall,
    input  wire wbps_pkg::in_item_t                      in_item,
    output logic                                         out_valid,
    input  wire logic                                    out_stall,
    output wbps_pkg::out_item_t                          out_item,
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [wbps_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [wbps_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
    import wbps_pkg::*;

    localparam int LEN_BITS = $clog2(PATTERN_MAX + 1);
    localparam logic [POSITION_BITS-1:0] COUNT_MAX = '1;

    // Register file.
    cfg_regs_t               cfg_reg;
    logic [LEN_REG_BITS-1:0] len_reg;
    logic [LEN_BITS-1:0]     len_eff;

    // Input stage.
    logic     s1_valid_reg;
    in_item_t s1_item_reg;

    // Search state: the byte window (entry 0 newest), the byte counter and the match flag.
    logic [PATTERN_MAX-1:0][7:0] window_reg;
    logic [PATTERN_MAX-1:0][7:0] window_next;
    logic [POSITION_BITS-1:0]    count_reg;
    logic [POSITION_BITS-1:0]    count_next;
    logic                        matched_reg;

    // Result register.
    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic                     advance;
    logic                     proc;
    logic                     in_fire;
    logic                     window_hit;
    logic                     enough;
    logic                     hit;
    logic                     emit;
    logic [POSITION_BITS-1:0] position_full;

    // Always ready; the user must give writes only while the block is idle (unchecked).
    assign cfg_ready = 1'b1;

    // A length above the window size uses the whole window.
    always_comb
    begin
        if (len_reg > LEN_REG_BITS'(PATTERN_MAX))
        begin
            len_eff = LEN_BITS'(PATTERN_MAX);
        end
        else
        begin
            len_eff = LEN_BITS'(len_reg);
        end
    end

    // The input stage moves on whenever the result register is free or being emptied,
    // so a waiting result never blocks the next byte unless the output is stalled.
    assign advance  = !out_valid_reg || !out_stall;
    assign proc     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign in_fire  = in_valid && !in_stall;

    // Window after the byte in the input stage is shifted in.
    always_comb
    begin
        window_next[0] = s1_item_reg.data_byte;
        for (int k = 1; k < PATTERN_MAX; k++)
        begin
            window_next[k] = window_reg[k-1];
        end
    end

    // The counter saturates; positions taken from a saturated count are not exact.
    assign count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    wbps_window_match #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_BITS    (LEN_BITS)
    ) u_match (
        .window     (window_next),
        .len_eff    (len_eff),
        .cfg        (cfg_reg),
        .window_hit (window_hit)
    );

    // A match needs a full window; a buffer shorter than the pattern never matches.
    assign enough        = count_next >= POSITION_BITS'(len_eff);
    assign hit           = enough && window_hit && !matched_reg;
    assign emit          = proc && !matched_reg && (hit || s1_item_reg.last_byte);
    assign position_full = count_next - POSITION_BITS'(len_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_bytes  <= '0;
            cfg_reg.element_kinds  <= '0;
            cfg_reg.variable_bytes <= VAR_BYTES_RESET;
            len_reg                <= LENGTH_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PATTERN_LOW:  cfg_reg.pattern_bytes[63:0]    <= cfg_data;
                REG_PATTERN_HIGH: cfg_reg.pattern_bytes[127:64]  <= cfg_data;
                REG_KINDS:        cfg_reg.element_kinds          <= cfg_data[31:0];
                REG_VAR_LOW:      cfg_reg.variable_bytes[63:0]   <= cfg_data;
                REG_VAR_HIGH:     cfg_reg.variable_bytes[127:64] <= cfg_data;
                REG_LENGTH:       len_reg                        <= cfg_data[LEN_REG_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= in_item;
        end
    end

    // Once a match is reported, bytes are ignored until the last byte of the buffer,
    // which always restarts the search.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= '0;
            count_reg   <= '0;
            matched_reg <= 1'b0;
        end
        else if (proc)
        begin
            if (s1_item_reg.last_byte)
            begin
                window_reg  <= '0;
                count_reg   <= '0;
                matched_reg <= 1'b0;
            end
            else if (!matched_reg)
            begin
                window_reg  <= window_next;
                count_reg   <= count_next;
                matched_reg <= hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_item_reg.found    <= hit;
            out_item_reg.position <= hit ? POS_OUT_BITS'(position_full) : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // A not-found result always carries position zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_item_reg.found) |-> (out_item_reg.position == '0))
        else $error("not-found result with nonzero position");

    // The input stage pushes back only while it holds a byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with an empty input stage");

    // After a match the counter is frozen until the buffer ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        (matched_reg && !(proc && s1_item_reg.last_byte)) |=> $stable(count_reg))
        else $error("byte counter moved after a match");

    // A match can only be recorded after at least one byte was counted.
    assert property (@(posedge clk) disable iff (!rst_n)
        matched_reg |-> (count_reg != '0))
        else $error("match flag set with an empty counter");

endmodule

`default_nettype wire

FILE: rtl/wbps_window_match.sv
`default_nettype none

module wbps_window_match #(
    parameter int PATTERN_MAX = 16,
    parameter int LEN_BITS    = 5
) (
    input  wire logic [PATTERN_MAX-1:0][7:0] window,
    input  wire logic [LEN_BITS-1:0]         len_eff,
    input  wire wbps_pkg::cfg_regs_t         cfg,
    output logic                             window_hit
);
    import wbps_pkg::*;

    localparam int IDX_BITS = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [PATTERN_MAX-1:0] elem_ok;

    // Element i lines up with the byte that arrived len - 1 - i items ago.
    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_elem
        logic [LEN_BITS-1:0] offset;
        logic [IDX_BITS-1:0] idx;
        logic [7:0]          got;
        logic [7:0]          want;
        logic [7:0]          subst;
        logic [1:0]          kind;

        always_comb
        begin
            offset = len_eff - LEN_BITS'(1) - LEN_BITS'(i);
            idx    = IDX_BITS'(offset);
            got    = window[idx];
            want   = cfg.pattern_bytes[8*i +: 8];
            subst  = cfg.variable_bytes[8*want[3:0] +: 8];
            kind   = cfg.element_kinds[2*i +: 2];
            if (LEN_BITS'(i) >= len_eff)
            begin
                elem_ok[i] = 1'b1;
            end
            else
            begin
                case (kind)
                    KIND_ANY:      elem_ok[i] = 1'b1;
                    KIND_VARIABLE: elem_ok[i] = (got == subst);
                    default:       elem_ok[i] = (got == want);
                endcase
            end
        end
    end

    assign window_hit = &elem_ok;

endmodule

`default_nettype wire

FILE: dv/wildcard_byte_pattern_search_unit_tb.sv
`timescale 1ns / 1ps

module wildcard_byte_pattern_search_unit_tb;
    import wbps_pkg::*;

    // The byte that causes a result item passes the input stage and the result register first.
    // Bytes that follow a match cause nothing, so an empty queue of expected
    // results does not prove that the block is idle. The settle time covers that.
    localparam int PIPE_LATENCY = 2;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 6;
    localparam int RANDOM_ITEMS = 560;
    localparam int PHASE_ITEMS = 90;
    localparam int CYCLE_LIMIT = 400000;
    localparam int COUNT_BITS = POSITION_BITS_DEF;

    typedef enum int
    {
        BUF_MATCH,
        BUF_PARTIAL,
        BUF_NOISE
    } buf_shape_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // Copy of the register file, as the search sees it.
    logic [8*ELEM_MAX_HW-1:0] cfg_pattern;
    logic [2*ELEM_MAX_HW-1:0] cfg_kinds;
    logic [8*ELEM_MAX_HW-1:0] cfg_vars;
    logic [LEN_REG_BITS-1:0] cfg_length;

    // Search state: byte window (entry 0 is the newest), byte counter and the
    // flag that silences the rest of a buffer once its match has been reported.
    logic [7:0] window_bytes [ELEM_MAX_HW];
    logic [COUNT_BITS-1:0] byte_count;
    logic match_done;

    out_item_t pending_results[$];
    int mismatch_count = 0;
    int bytes_sent = 0;
    int cycle_count = 0;

    // Stall controls shared between the test tasks and the receiver process.
    bit calm = 1'b0;
    int hold_request = 0;

    wildcard_byte_pattern_search_unit u_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Pattern length in use: anything above the window size acts as a full window.
    function automatic int active_length();
        return (cfg_length > ELEM_MAX_HW) ? ELEM_MAX_HW : int'(cfg_length);
    endfunction

    // Advances the search by one accepted byte. Returns 1 when the byte causes a
    // result item, which is then given in res.
    function automatic bit predict_search(input in_item_t beat, output out_item_t res);
        int n;
        logic [7:0] want;
        logic [1:0] kind;
        bit hit;
        bit emit;
        n = active_length();
        emit = 1'b0;
        res = '0;
        if (!match_done)
        begin
            for (int i = ELEM_MAX_HW - 1; i > 0; i--)
                window_bytes[i] = window_bytes[i-1];
            window_bytes[0] = beat.data_byte;
            if (byte_count != '1)
                byte_count++;

            // Element i lines up with the byte that arrived n-1-i steps ago.
            hit = (byte_count >= COUNT_BITS'(n));
            for (int i = 0; i < n; i++)
            begin
                want = cfg_pattern[8*i +: 8];
                kind = cfg_kinds[2*i +: 2];
                if (kind == KIND_VARIABLE)
                    want = cfg_vars[8*want[3:0] +: 8];
                if (kind != KIND_ANY && window_bytes[n-1-i] != want)
                    hit = 1'b0;
            end

            if (hit)
            begin
                match_done = 1'b1;
                res.found = 1'b1;
                res.position = POS_OUT_BITS'(byte_count - COUNT_BITS'(n));
                emit = 1'b1;
            end
            else if (beat.last_byte)
            begin
                emit = 1'b1;
            end
        end

        // The final byte of a buffer always restarts the search.
        if (beat.last_byte)
        begin
            foreach (window_bytes[i])
                window_bytes[i] = 8'h00;
            byte_count = '0;
            match_done = 1'b0;
        end
        return emit;
    endfunction

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // Output check first, then prediction for the byte accepted at this edge.
    // Both sample values from before the edge, so event order does not matter.
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                flag_error($sformatf("unexpected result found=%0b position=%0d",
                                     out_item.found, out_item.position));
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_item.found !== want.found)
                    flag_error($sformatf("found expected %0b got %0b",
                                         want.found, out_item.found));
                if (out_item.position !== want.position)
                    flag_error($sformatf("position expected %0d got %0d",
                                         want.position, out_item.position));
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            if (predict_search(in_item, res))
                pending_results.push_back(res);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Idle lengths: mostly short, now and then a long one.
    function automatic int idle_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // The receiver stalls at random. A hold-off requested by a test keeps the
    // stall up for the requested time, counted here, no matter what the sender does.
    initial
    begin
        int hold_left;
        int stall_left;
        hold_left = 0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 99) < 25)
            begin
                out_stall <= 1'b1;
                stall_left = idle_length() - 1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Offers one byte, after a random gap, and returns at the edge that takes it.
    // Valid stays up into the next call when that call has no gap.
    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        gap = (calm || $urandom_range(0, 9) < 7) ? 0 : idle_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{data_byte: value, last_byte: last};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Drops valid and waits for every expected result.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Registers are only written once the block has nothing left in flight.
    task automatic settle_block();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Writes the whole register file back to back. Unused upper bits of the
    // kinds and length words carry random data, which the block must drop.
    task automatic apply_config(input logic [8*ELEM_MAX_HW-1:0] pat,
                                input logic [2*ELEM_MAX_HW-1:0] kinds,
                                input logic [8*ELEM_MAX_HW-1:0] vars,
                                input logic [LEN_REG_BITS-1:0] len);
        write_reg(REG_PATTERN_LOW, pat[63:0]);
        write_reg(REG_PATTERN_HIGH, pat[127:64]);
        write_reg(REG_KINDS, {32'($urandom), kinds});
        write_reg(REG_VAR_LOW, vars[63:0]);
        write_reg(REG_VAR_HIGH, vars[127:64]);
        write_reg(REG_LENGTH, {32'($urandom), 27'($urandom), len});
        cfg_valid <= 1'b0;
        cfg_pattern = pat;
        cfg_kinds = kinds;
        cfg_vars = vars;
        cfg_length = len;
    endtask

    function automatic logic [127:0] random_wide();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // A byte that satisfies pattern element idx under the current settings.
    function automatic logic [7:0] element_value(input int idx);
        logic [7:0] pb;
        pb = cfg_pattern[8*idx +: 8];
        case (cfg_kinds[2*idx +: 2])
            KIND_ANY:      return 8'($urandom);
            KIND_VARIABLE: return cfg_vars[8*pb[3:0] +: 8];
            default:       return pb;
        endcase
    endfunction

    function automatic buf_shape_t pick_shape();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return BUF_MATCH;
        if (r < 85)
            return BUF_PARTIAL;
        return BUF_NOISE;
    endfunction

    function automatic int pick_lead();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
    endfunction

    // One buffer: random lead-in, then the full pattern, a cut-short pattern
    // or nothing, random tail bytes only after a full pattern, and the final byte marked.
    task automatic send_buffer(input buf_shape_t shape, input int lead);
        logic [7:0] bytes_q[$];
        int n;
        int cut;
        int tail;
        n = active_length();
        for (int i = 0; i < lead; i++)
            bytes_q.push_back(8'($urandom));
        if (shape != BUF_NOISE)
        begin
            cut = (shape == BUF_PARTIAL && n > 0) ? $urandom_range(0, n - 1) : n;
            for (int i = 0; i < cut; i++)
                bytes_q.push_back(element_value(i));
        end
        tail = (shape == BUF_MATCH) ? $urandom_range(0, 4) : 0;
        for (int i = 0; i < tail; i++)
            bytes_q.push_back(8'($urandom));
        if (bytes_q.size() == 0)
            bytes_q.push_back(8'($urandom));
        foreach (bytes_q[i])
            send_byte(bytes_q[i], i == bytes_q.size() - 1);
    endtask

    // Reset settings: a one-element literal pattern of 0x00.
    task automatic test_reset_defaults();
        send_byte(8'h12, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(8'hf0, 1'b1);
    endtask

    // One element of each kind; the variable element has a nonzero high nibble,
    // which must not take part in the selection. Bytes after the match are dropped.
    task automatic test_element_kinds();
        logic [8*ELEM_MAX_HW-1:0] vars;
        settle_block();
        vars = random_wide();
        apply_config({$urandom, $urandom, 32'h5ca3_00ff},
                     {24'($urandom), KIND_LITERAL_ALT, KIND_VARIABLE, KIND_ANY, KIND_LITERAL},
                     vars, 5'd4);
        send_byte(8'h01, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h77, 1'b0);
        send_byte(vars[8*3 +: 8], 1'b0);
        send_byte(8'h5c, 1'b0);
        send_byte(8'h99, 1'b0);
        send_byte(8'h2e, 1'b1);
    endtask

    // A pattern of no elements matches as soon as the first byte arrives.
    task automatic test_empty_pattern();
        settle_block();
        apply_config(random_wide(), $urandom, random_wide(), 5'd0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // A buffer shorter than the pattern never completes a window.
    task automatic test_short_buffer();
        settle_block();
        apply_config({104'($urandom), 24'h2e2e2e}, 32'h0, random_wide(), 5'd3);
        send_byte(8'h2e, 1'b0);
        send_byte(8'h2e, 1'b1);
    endtask

    // The window completes on the final byte: only the found item comes out.
    task automatic test_match_on_last_byte();
        send_byte(8'h00, 1'b0);
        send_byte(8'h2e, 1'b0);
        send_byte(8'h2e, 1'b0);
        send_byte(8'h2e, 1'b1);
    endtask

    // A one-element wildcard makes every one-byte buffer a result. The receiver
    // holds off long enough for the block to fill and stall the sender.
    task automatic test_backpressure();
        settle_block();
        apply_config(random_wide(), {16{KIND_ANY}}, random_wide(), 5'd1);
        calm = 1'b1;
        hold_request = 300;
        repeat (40)
            send_byte(8'($urandom), 1'b1);
        calm = 1'b0;
    endtask

    // The sender stops until every result is back, then carries on with the
    // same settings and the search state left as it was.
    task automatic test_drain_pause();
        settle_block();
        apply_config(random_wide(), $urandom, random_wide(), 5'($urandom_range(1, 5)));
        repeat (5)
            send_buffer(pick_shape(), pick_lead());
        wait_drained();
        repeat (5)
            send_buffer(pick_shape(), pick_lead());
    endtask

    // Phases of random settings. The first two use all-zero and all-one pattern, kinds
    // and variable bytes, with length 16 and 31; every third phase runs without idling on either side.
    task automatic test_random_buffers();
        logic [8*ELEM_MAX_HW-1:0] pat;
        logic [8*ELEM_MAX_HW-1:0] vars;
        logic [2*ELEM_MAX_HW-1:0] kinds;
        logic [LEN_REG_BITS-1:0] len;
        int r;
        int phase;
        int start;
        int phase_start;
        phase = 0;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_ITEMS)
        begin
            settle_block();
            if (phase == 0)
            begin
                pat = '0;
                kinds = '0;
                vars = '0;
                len = 5'd16;
            end
            else if (phase == 1)
            begin
                pat = '1;
                kinds = '1;
                vars = '1;
                len = '1;
            end
            else
            begin
                pat = random_wide();
                kinds = $urandom;
                vars = random_wide();
                r = $urandom_range(0, 99);
                if (r < 8)
                    len = 5'd0;
                else if (r < 18)
                    len = 5'($urandom_range(17, 31));
                else if (r < 35)
                    len = 5'($urandom_range(7, 16));
                else
                    len = 5'($urandom_range(1, 6));
            end
            apply_config(pat, kinds, vars, len);
            calm = (phase % 3 == 2);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_ITEMS)
                send_buffer(pick_shape(), pick_lead());
            phase++;
        end
        calm = 1'b0;
    endtask

    initial
    begin
        cfg_pattern = '0;
        cfg_kinds = '0;
        cfg_vars = VAR_BYTES_RESET;
        cfg_length = LENGTH_RESET;
        foreach (window_bytes[i])
            window_bytes[i] = 8'h00;
        byte_count = '0;
        match_done = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_element_kinds();
        test_empty_pattern();
        test_short_buffer();
        test_match_on_last_byte();
        test_backpressure();
        test_drain_pause();
        test_random_buffers();

        // Wait out the last results plus a settle time for anything spurious.
        settle_block();
        if (pending_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_results.size()));

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: wildcard_byte_pattern_search_unit.f
rtl/wbps_pkg.sv
rtl/wbps_window_match.sv
rtl/wildcard_byte_pattern_search_unit.sv
dv/wildcard_byte_pattern_search_unit_tb.sv
